// ===== hdl/mbc3_bank_and_rtc_controller_macros.svh =====
// Assertion macros shared by the bank and clock controller RTL.
`ifndef MBC3_BANK_AND_RTC_CONTROLLER_MACROS_SVH
`define MBC3_BANK_AND_RTC_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Invariant that holds at every edge outside reset.
`define MBC3_ASSERT_ALWAYS(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("mbc3 invariant failed");
// Condition in a cycle implies a consequence in the same cycle.
`define MBC3_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("mbc3 implication failed");
`else
`define MBC3_ASSERT_ALWAYS(name, clk, rst_n, cond)
`define MBC3_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/mbc3c_pkg.sv =====
// Types, constants and helpers of the bank and clock controller.
`default_nettype none
package mbc3c_pkg;

	// Control area decode on address bits 14..13 (bit 15 low)
	localparam logic [1:0] REGION_ENABLE = 2'd0;
	localparam logic [1:0] REGION_ROM    = 2'd1;
	localparam logic [1:0] REGION_SELECT = 2'd2;
	localparam logic [1:0] REGION_LATCH  = 2'd3;

	localparam logic [3:0] ENABLE_KEY    = 4'hA;
	localparam logic [7:0] RAM_BANK_MAX  = 8'h03;
	localparam logic [7:0] CLK_SEL_FIRST = 8'h08;
	localparam logic [7:0] CLK_SEL_LAST  = 8'h0C;
	localparam logic [3:0] CLK_SEL_BIAS  = 4'd7;
	localparam logic [2:0] CLK_SEL_NONE  = 3'd0;
	localparam logic [2:0] CLK_SEL_MAX   = 3'd5;
	localparam logic [7:0] LATCH_ARM     = 8'h00;
	localparam logic [7:0] LATCH_FIRE    = 8'h01;

	localparam logic [6:0] MINUTE_SPAN   = 7'd60;
	localparam logic [6:0] MINUTE_LAST   = 7'd59;
	localparam logic [5:0] DAY_HOURS     = 6'd24;
	localparam logic [5:0] HOUR_LAST     = 6'd23;

	localparam int DH_CARRY = 7;
	localparam int DH_HALT  = 6;
	localparam int DH_DAY8  = 0;

	localparam logic [6:0] ROM_BANK_RST  = 7'd1;
	localparam logic [6:0] ROM_BANK_ZERO = 7'd0;

	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [5:0]  elapsed_seconds;
		logic [5:0]  elapsed_minutes;
		logic [4:0]  elapsed_hours;
		logic [8:0]  elapsed_days;
	} mbc3c_wr_t;

	typedef struct packed {
		logic       ram_enable;
		logic [6:0] rom_bank;
		logic [1:0] ram_bank;
		logic [2:0] clock_select;
		logic [7:0] bank_select_raw;
		logic [5:0] clock_seconds;
		logic [5:0] clock_minutes;
		logic [4:0] clock_hours;
		logic [7:0] clock_day_low;
		logic [7:0] clock_day_high;
	} mbc3c_res_t;

	typedef struct packed {
		logic       ram_en;
		logic [6:0] rom_bank;
		logic [1:0] ram_bank;
		logic [2:0] clk_sel;
		logic [7:0] select_raw;
		logic [5:0] rtc_sec;
		logic [5:0] rtc_min;
		logic [4:0] rtc_hour;
		logic [7:0] day_low;
		logic [7:0] day_high;
		logic       latch_armed;
	} mbc3c_state_t;

	localparam mbc3c_state_t STATE_RST = '{
		ram_en: 1'b0, rom_bank: ROM_BANK_RST, ram_bank: 2'd0, clk_sel: CLK_SEL_NONE,
		select_raw: 8'd0, rtc_sec: 6'd0, rtc_min: 6'd0, rtc_hour: 5'd0,
		day_low: 8'd0, day_high: 8'd0, latch_armed: 1'b0
	};

	// Present the controller state as a result item; bank 0 reads as bank 1
	function automatic mbc3c_res_t state_to_res(input mbc3c_state_t st);
		mbc3c_res_t r;
		r.ram_enable      = st.ram_en;
		r.rom_bank        = (st.rom_bank == ROM_BANK_ZERO) ? ROM_BANK_RST : st.rom_bank;
		r.ram_bank        = st.ram_bank;
		r.clock_select    = st.clk_sel;
		r.bank_select_raw = st.select_raw;
		r.clock_seconds   = st.rtc_sec;
		r.clock_minutes   = st.rtc_min;
		r.clock_hours     = st.rtc_hour;
		r.clock_day_low   = st.day_low;
		r.clock_day_high  = st.day_high;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mbc3_bank_and_rtc_controller.sv =====
// Top level of the cartridge bank controller with real-time clock.
//
// Usage:
//   Write channel (wr_valid / wr_stall / wr): one processor write to the
//   control area per item, with the elapsed interval to apply if the write
//   completes a latch sequence (a write of 0, then a write of 1, to the
//   latch area). Address bits 14..13 pick enable, ROM bank, RAM bank or
//   clock select, or latch; bit 15 set writes nothing.
//   Result channel (res_valid / res_stall / res): one item per write, the
//   controller state as it stands after that write.
//   The path is one input register, then the decode and clock carry chain
//   into the result register. Throughput is one item per cycle while the
//   result side does not stall; the carry chain through seconds, minutes,
//   hours and days is the longest path.
//   A stalled result holds in its register; the input register still takes
//   one more item, and wr_stall rises only when both are full.
//   Reset clears both stages and sets the state to its power-up values:
//   RAM disabled, ROM bank 1, RAM bank 0, no clock register, clock at zero.
`default_nettype none
`include "mbc3_bank_and_rtc_controller_macros.svh"
module mbc3_bank_and_rtc_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_stall,
	input  mbc3c_pkg::mbc3c_wr_t  wr,
	output logic                  res_valid,
	input  logic                  res_stall,
	output mbc3c_pkg::mbc3c_res_t res
);
	import mbc3c_pkg::*;

	logic         wr_valid_s1;
	mbc3c_wr_t    wr_item_s1;
	logic         res_valid_q;
	mbc3c_res_t   res_q;
	mbc3c_state_t state_q;
	mbc3c_state_t state_nxt;
	logic         wr_take;
	logic         s1_move;

	// Move the held write into the result register whenever that register
	// is empty or being drained this cycle.
	assign s1_move  = wr_valid_s1 && (!res_valid_q || !res_stall);
	// Stall the writer only when the input register cannot empty.
	assign wr_stall = wr_valid_s1 && res_valid_q && res_stall;
	assign wr_take  = wr_valid && !wr_stall;

	// Input stage: hold the write until it moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s1 <= 1'b0;
		end else if (wr_take) begin
			wr_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			wr_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_take) begin
			wr_item_s1 <= wr;
		end
	end

	// Decode the write and run the clock advance against the current state.
	mbc3c_update u_update (
		.cur  (state_q),
		.item (wr_item_s1),
		.nxt  (state_nxt)
	);

	// Controller state advances exactly once per write, as it moves out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (s1_move) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on move, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_move) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_q <= state_to_res(state_nxt);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks on the controller's own logic.
	`MBC3_ASSERT_IMPLY(a_rom_bank_nonzero, clk, arst_n, res_valid, res.rom_bank != ROM_BANK_ZERO)
	`MBC3_ASSERT_IMPLY(a_stall_only_full, clk, arst_n, wr_stall, wr_valid_s1 && res_valid_q)
	`MBC3_ASSERT_ALWAYS(a_day_high_unused_clear, clk, arst_n, state_q.day_high[5:1] == 5'd0)
	`MBC3_ASSERT_ALWAYS(a_clk_sel_range, clk, arst_n, state_q.clk_sel <= CLK_SEL_MAX)

endmodule
`default_nettype wire

// ===== hdl/mbc3c_update.sv =====
// Next-state logic of the controller for one bus write.
`default_nettype none
module mbc3c_update (
	input  mbc3c_pkg::mbc3c_state_t cur,
	input  mbc3c_pkg::mbc3c_wr_t    item,
	output mbc3c_pkg::mbc3c_state_t nxt
);
	import mbc3c_pkg::*;

	logic [1:0] region;
	logic [6:0] sec_sum, sec_wrap;
	logic [6:0] min_sum, min_wrap;
	logic [5:0] hour_sum, hour_wrap;
	logic [9:0] day_sum;
	logic       sec_cy, min_cy, hour_cy;

	assign region = item.address[14:13];

	// Clock advance: seconds -> minutes -> hours -> 9-bit days
	assign sec_sum  = {1'b0, cur.rtc_sec} + {1'b0, item.elapsed_seconds};
	assign sec_cy   = sec_sum > MINUTE_LAST;
	assign sec_wrap = sec_sum - MINUTE_SPAN;

	assign min_sum  = {1'b0, cur.rtc_min} + {1'b0, item.elapsed_minutes} + {6'd0, sec_cy};
	assign min_cy   = min_sum > MINUTE_LAST;
	assign min_wrap = min_sum - MINUTE_SPAN;

	assign hour_sum  = {1'b0, cur.rtc_hour} + {1'b0, item.elapsed_hours} + {5'd0, min_cy};
	assign hour_cy   = hour_sum > HOUR_LAST;
	assign hour_wrap = hour_sum - DAY_HOURS;

	assign day_sum = {1'b0, cur.day_high[DH_DAY8], cur.day_low}
		+ {1'b0, item.elapsed_days} + {9'd0, hour_cy};

	always_comb begin
		nxt = cur;
		if (!item.address[15]) begin
			unique case (region)
				REGION_ENABLE: begin
					nxt.ram_en = (item.write_data[3:0] == ENABLE_KEY);
				end
				REGION_ROM: begin
					nxt.rom_bank = item.write_data[6:0];
				end
				REGION_SELECT: begin
					nxt.select_raw = item.write_data;
					if (item.write_data <= RAM_BANK_MAX) begin
						nxt.ram_bank = item.write_data[1:0];
						nxt.clk_sel  = CLK_SEL_NONE;
					end else if (item.write_data >= CLK_SEL_FIRST &&
						item.write_data <= CLK_SEL_LAST) begin
						nxt.clk_sel = 3'(item.write_data[3:0] - CLK_SEL_BIAS);
					end
				end
				REGION_LATCH: begin
					if (item.write_data == LATCH_ARM) begin
						nxt.latch_armed = 1'b1;
					end else if (item.write_data == LATCH_FIRE && cur.latch_armed) begin
						nxt.latch_armed = 1'b0;
						if (!cur.day_high[DH_HALT]) begin
							nxt.rtc_sec  = sec_cy ? sec_wrap[5:0] : sec_sum[5:0];
							nxt.rtc_min  = min_cy ? min_wrap[5:0] : min_sum[5:0];
							nxt.rtc_hour = hour_cy ? hour_wrap[4:0] : hour_sum[4:0];
							nxt.day_low  = day_sum[7:0];
							// carry is sticky; bits 5..1 drop on every advance
							nxt.day_high = {cur.day_high[DH_CARRY] | day_sum[9],
								cur.day_high[DH_HALT], 5'd0, day_sum[8]};
						end
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the bank and clock controller: directed and random writes checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
	import mbc3c_pkg::*;

	localparam int DAY_LIMIT  = 511;
	localparam int RAND_ITEMS = 1100;
	localparam int HOLD_CYCLES = 200;

	// Tracks the controller state from accepted writes and checks each result item
	class controller_scoreboard;
		logic       ram_on;
		logic [6:0] rom_sel;
		logic [1:0] ram_sel;
		logic [2:0] clk_sel;
		logic [7:0] sel_raw;
		logic [5:0] secs;
		logic [5:0] mins;
		logic [4:0] hours;
		logic [7:0] day_lo;
		logic [7:0] day_hi;
		logic       armed;
		mbc3c_res_t expected_states[$];
		int         fails;
		int         results_seen;

		function new();
			ram_on  = 1'b0;
			rom_sel = ROM_BANK_RST;
			ram_sel = '0;
			clk_sel = CLK_SEL_NONE;
			sel_raw = '0;
			secs    = '0;
			mins    = '0;
			hours   = '0;
			day_lo  = '0;
			day_hi  = '0;
			armed   = 1'b0;
			fails   = 0;
			results_seen = 0;
		endfunction

		function void report(string msg);
			fails++;
			$display("ERROR at %0t: %s", $time, msg);
		endfunction

		// Add the elapsed interval with carries from seconds up to the 9-bit day count
		function void apply_interval(mbc3c_wr_t w);
			int s;
			int carry;
			int day;
			s = secs + w.elapsed_seconds;
			carry = 0;
			if (s > MINUTE_LAST) begin
				s = s - MINUTE_SPAN;
				carry = 1;
			end
			secs = s[5:0];
			s = mins + w.elapsed_minutes + carry;
			carry = 0;
			if (s > MINUTE_LAST) begin
				s = s - MINUTE_SPAN;
				carry = 1;
			end
			mins = s[5:0];
			s = hours + w.elapsed_hours + carry;
			carry = 0;
			if (s > HOUR_LAST) begin
				s = s - DAY_HOURS;
				carry = 1;
			end
			hours = s[4:0];
			day = {day_hi[DH_DAY8], day_lo} + w.elapsed_days + carry;
			if (day > DAY_LIMIT) begin
				// day carry is sticky
				day_hi[DH_CARRY] = 1'b1;
				day = day & 'h1FF;
			end
			day_hi = day_hi & 8'hC0;
			day_hi[DH_DAY8] = day[8];
			day_lo = day[7:0];
		endfunction

		function void note_write(mbc3c_wr_t w);
			logic [7:0] d;
			mbc3c_res_t e;
			d = w.write_data;
			if (!w.address[15]) begin
				case (w.address[14:13])
					REGION_ENABLE: ram_on = (d[3:0] == ENABLE_KEY);
					REGION_ROM: rom_sel = d[6:0];
					REGION_SELECT: begin
						sel_raw = d;
						if (d <= RAM_BANK_MAX) begin
							ram_sel = d[1:0];
							clk_sel = CLK_SEL_NONE;
						end else if (d >= CLK_SEL_FIRST && d <= CLK_SEL_LAST) begin
							clk_sel = 3'(d - CLK_SEL_BIAS);
						end
					end
					REGION_LATCH: begin
						if (d == LATCH_ARM) begin
							armed = 1'b1;
						end else if (d == LATCH_FIRE && armed) begin
							armed = 1'b0;
							if (!day_hi[DH_HALT])
								apply_interval(w);
						end
					end
				endcase
			end
			e.ram_enable      = ram_on;
			e.rom_bank        = (rom_sel == ROM_BANK_ZERO) ? ROM_BANK_RST : rom_sel;
			e.ram_bank        = ram_sel;
			e.clock_select    = clk_sel;
			e.bank_select_raw = sel_raw;
			e.clock_seconds   = secs;
			e.clock_minutes   = mins;
			e.clock_hours     = hours;
			e.clock_day_low   = day_lo;
			e.clock_day_high  = day_hi;
			expected_states.push_back(e);
		endfunction

		function void compare_field(string name, int got, int want);
			if (got != want)
				report($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
					results_seen, name, got, want));
		endfunction

		function void check_result(mbc3c_res_t r);
			mbc3c_res_t e;
			if (expected_states.size() == 0) begin
				report($sformatf("result %0d arrived with no write pending", results_seen));
			end else begin
				e = expected_states.pop_front();
				compare_field("ram_enable", r.ram_enable, e.ram_enable);
				compare_field("rom_bank", r.rom_bank, e.rom_bank);
				compare_field("ram_bank", r.ram_bank, e.ram_bank);
				compare_field("clock_select", r.clock_select, e.clock_select);
				compare_field("bank_select_raw", r.bank_select_raw, e.bank_select_raw);
				compare_field("clock_seconds", r.clock_seconds, e.clock_seconds);
				compare_field("clock_minutes", r.clock_minutes, e.clock_minutes);
				compare_field("clock_hours", r.clock_hours, e.clock_hours);
				compare_field("clock_day_low", r.clock_day_low, e.clock_day_low);
				compare_field("clock_day_high", r.clock_day_high, e.clock_day_high);
			end
			results_seen++;
		endfunction

		function int pending();
			return expected_states.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_valid;
	logic       wr_stall;
	mbc3c_wr_t  wr;
	logic       res_valid;
	logic       res_stall;
	mbc3c_res_t res;

	controller_scoreboard board = new();
	mbc3c_wr_t write_plan[$];
	int        writes_taken = 0;
	bit        hold_off = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	mbc3_bank_and_rtc_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_valid  (wr_valid),
		.wr_stall  (wr_stall),
		.wr        (wr),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Idle length: mostly none, often a short gap, now and then a long one
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Control write to one decode region at a random address inside it, no interval
	function automatic mbc3c_wr_t ctl_write(logic [1:0] region, logic [7:0] data);
		mbc3c_wr_t w;
		w = '0;
		w.address = {1'b0, region, 13'($urandom)};
		w.write_data = data;
		return w;
	endfunction

	// Any write at all; data leans toward the codes the decoder looks for
	function automatic mbc3c_wr_t random_write();
		mbc3c_wr_t w;
		int r;
		w = mbc3c_wr_t'({$urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 10)
			w.write_data = {4'($urandom), ENABLE_KEY};
		else if (r < 20)
			w.write_data = 8'($urandom_range(0, RAM_BANK_MAX));
		else if (r < 30)
			w.write_data = 8'($urandom_range(CLK_SEL_FIRST, CLK_SEL_LAST));
		else if (r < 38)
			w.write_data = ($urandom_range(0, 1) != 0) ? LATCH_ARM : LATCH_FIRE;
		return w;
	endfunction

	// Closing write of a latch sequence; mostly a legal interval, sometimes raw bits
	function automatic mbc3c_wr_t latch_fire();
		mbc3c_wr_t w;
		w = ctl_write(REGION_LATCH, LATCH_FIRE);
		if ($urandom_range(0, 3) != 0) begin
			w.elapsed_seconds = 6'($urandom_range(0, 59));
			w.elapsed_minutes = 6'($urandom_range(0, 59));
			w.elapsed_hours   = 5'($urandom_range(0, 23));
			w.elapsed_days    = 9'($urandom_range(0, 511));
		end else begin
			w.elapsed_seconds = 6'($urandom);
			w.elapsed_minutes = 6'($urandom);
			w.elapsed_hours   = 5'($urandom);
			w.elapsed_days    = 9'($urandom);
		end
		return w;
	endfunction

	// Offer one item after an idle gap; hold it until the block takes it
	task automatic drive_write(input mbc3c_wr_t w, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			wr_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		wr_valid <= 1'b1;
		wr <= w;
		do
			@(posedge clk);
		while (wr_stall);
		board.note_write(w);
		writes_taken++;
	endtask

	// Result side: random stalls, quiet windows, and the long hold-off on request
	task automatic run_result_side();
		int stall_left;
		int cycle;
		stall_left = 0;
		cycle = 0;
		forever begin
			@(negedge clk);
			cycle++;
			if (stall_left == 0 && (cycle / 400) % 4 != 3 && $urandom_range(0, 99) < 25)
				stall_left = pick_idle();
			res_stall <= hold_off || (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	endtask

	// Check every result item the moment the handshake completes
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(res);
	end

	// Once traffic is well under way, hold off the result side long enough
	// that both pipeline stages fill and the block stalls its input
	initial begin
		wait (writes_taken >= 500);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		mbc3c_wr_t w;
		int idx;
		int gap;
		int fill;

		arst_n    = 1'b0;
		wr_valid  = 1'b0;
		wr        = '0;
		res_stall = 1'b0;

		// Directed part: field extremes, every decode region and the corner cases
		w = '0;
		w.address = 16'h8000;
		w.write_data = 8'hFF;
		write_plan.push_back(w);                              // upper area ignored
		w = ctl_write(REGION_ENABLE, {4'h0, ENABLE_KEY});
		w.address = 16'h0000;
		write_plan.push_back(w);
		write_plan.push_back(ctl_write(REGION_ENABLE, {4'hF, ENABLE_KEY}));
		write_plan.push_back(ctl_write(REGION_ENABLE, 8'h0B));  // wrong key clears
		write_plan.push_back(ctl_write(REGION_ROM, 8'h00));     // bank 0 reads as 1
		write_plan.push_back(ctl_write(REGION_ROM, 8'hFF));
		write_plan.push_back(ctl_write(REGION_ROM, 8'h80));     // masks to 0
		write_plan.push_back(ctl_write(REGION_SELECT, RAM_BANK_MAX));
		write_plan.push_back(ctl_write(REGION_SELECT, CLK_SEL_FIRST));
		write_plan.push_back(ctl_write(REGION_SELECT, CLK_SEL_LAST));
		write_plan.push_back(ctl_write(REGION_SELECT, 8'h04));  // unused select values
		write_plan.push_back(ctl_write(REGION_SELECT, 8'h0D));
		write_plan.push_back(ctl_write(REGION_SELECT, 8'hFF));
		write_plan.push_back(ctl_write(REGION_SELECT, 8'h00));
		w = ctl_write(REGION_LATCH, LATCH_FIRE);               // fire while not armed
		w.elapsed_seconds = 6'd30;
		write_plan.push_back(w);
		write_plan.push_back(ctl_write(REGION_LATCH, LATCH_ARM));
		write_plan.push_back(ctl_write(REGION_LATCH, 8'h05));   // keeps the latch armed
		w = ctl_write(REGION_LATCH, LATCH_FIRE);
		w.elapsed_seconds = 6'd59;
		w.elapsed_minutes = 6'd59;
		w.elapsed_hours   = 5'd23;
		w.elapsed_days    = 9'd511;
		write_plan.push_back(w);
		write_plan.push_back(ctl_write(REGION_LATCH, LATCH_ARM));
		w = ctl_write(REGION_LATCH, LATCH_FIRE);               // interval past its range
		w.elapsed_seconds = 6'h3F;
		w.elapsed_minutes = 6'h3F;
		w.elapsed_hours   = 5'h1F;
		w.elapsed_days    = 9'h1FF;
		write_plan.push_back(w);
		write_plan.push_back(ctl_write(REGION_LATCH, LATCH_ARM));
		w.address = 16'h7FFF;                                  // day wrap again, carry stays
		write_plan.push_back(w);
		w = '1;
		write_plan.push_back(w);
		write_plan.push_back(ctl_write(REGION_LATCH, LATCH_FIRE));

		// Random part: mostly full latch sequences with noise between, rest free writes
		while (write_plan.size() < RAND_ITEMS + 24) begin
			if ($urandom_range(0, 99) < 45) begin
				write_plan.push_back(ctl_write(REGION_LATCH, LATCH_ARM));
				fill = $urandom_range(0, 3);
				repeat (fill) write_plan.push_back(random_write());
				write_plan.push_back(latch_fire());
			end else begin
				write_plan.push_back(random_write());
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		fork
			run_result_side();
		join_none

		idx = 0;
		foreach (write_plan[i]) begin
			gap = pick_idle();
			// back-to-back windows with no sender idling
			if ((idx / 128) % 3 == 2)
				gap = 0;
			drive_write(write_plan[i], gap);
			idx++;
		end
		@(negedge clk);
		wr_valid <= 1'b0;

		// Drain, then give any stray result time to show up
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (board.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mbc3c_pkg.sv
hdl/mbc3c_update.sv
hdl/mbc3_bank_and_rtc_controller.sv
sim/tb_top.sv
